FILE: hdl/quadratic_root_solver_core_defines.svh
// Assertion macros used by the port-level checker of the root solver.
`ifndef QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH
`define QUADRATIC_ROOT_SOLVER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define QRS_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/qrs_pkg.sv
// Shared widths, constants and codes of the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;
	localparam int COEF_W            = 16;
	localparam int DISC_W            = 34;
	localparam int ROOT_W            = 34;
	localparam int DEN_W             = 17;
	localparam int FRACTION_BITS_DEF = 16;

	localparam logic [ROOT_W-1:0] ROOT_MAX = {1'b0, {(ROOT_W-1){1'b1}}};
	localparam logic [ROOT_W-1:0] ROOT_MIN = {1'b1, {(ROOT_W-1){1'b0}}};

	typedef enum logic [1:0] {
		CASE_TWO    = 2'd0,
		CASE_DOUBLE = 2'd1,
		CASE_NONE   = 2'd2,
		CASE_LINEAR = 2'd3
	} root_case_t;
endpackage
`default_nettype wire

FILE: hdl/qrs_coef_if.sv
// Coefficient request channel.
`timescale 1ns / 1ps
`default_nettype none
interface qrs_coef_if import qrs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [COEF_W-1:0] coef_a;
	logic signed [COEF_W-1:0] coef_b;
	logic signed [COEF_W-1:0] coef_c;

	modport source (output valid, coef_a, coef_b, coef_c, input ready);
	modport sink   (input valid, coef_a, coef_b, coef_c, output ready);
endinterface
`default_nettype wire

FILE: hdl/qrs_root_if.sv
// Result channel carrying discriminant, case code and both roots.
`timescale 1ns / 1ps
`default_nettype none
interface qrs_root_if import qrs_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic signed [DISC_W-1:0] discriminant;
	logic [1:0]               root_case;
	logic signed [ROOT_W-1:0] root_plus;
	logic signed [ROOT_W-1:0] root_minus;

	modport source (output valid, discriminant, root_case, root_plus, root_minus,
		input ready);
	modport sink   (input valid, discriminant, root_case, root_plus, root_minus,
		output ready);
endinterface
`default_nettype wire

FILE: hdl/qrs_sqrt.sv
// Pipelined fixed-point square root, one root bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_sqrt import qrs_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic [DISC_W-1:0]               d,
	output      logic [DISC_W/2+FRACTION_BITS-1:0] s
);
	localparam int N = DISC_W / 2 + FRACTION_BITS;

	logic [DISC_W-1:0] d_s   [1:N];
	logic [N-1:0]      r_s   [1:N];
	logic [N+1:0]      rem_s [1:N];

	for (genvar j = 1; j <= N; j++) begin : g_stage
		localparam int I = N - j;
		logic [DISC_W-1:0] pd;
		logic [N-1:0]      pr;
		logic [N+1:0]      prem;
		logic [1:0]        pair;
		logic [N+1:0]      shifted;
		logic [N+1:0]      trial;
		logic              ge;

		if (j == 1) begin : g_first
			assign pd   = d;
			assign pr   = '0;
			assign prem = '0;
		end else begin : g_next
			assign pd   = d_s[j-1];
			assign pr   = r_s[j-1];
			assign prem = rem_s[j-1];
		end

		// Below the fraction point the radicand brings in zero pairs.
		if (I >= FRACTION_BITS) begin : g_pair
			assign pair = pd[2*(I-FRACTION_BITS)+1 -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign shifted = {prem[N-1:0], pair};
		assign trial   = {pr, 2'b01};
		assign ge      = shifted >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				d_s[j]   <= pd;
				r_s[j]   <= {pr[N-2:0], ge};
				rem_s[j] <= ge ? shifted - trial : shifted;
			end
		end
	end

	assign s = r_s[N];
endmodule
`default_nettype wire

FILE: hdl/qrs_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div import qrs_pkg::*; #(
	parameter int NW = FRACTION_BITS_DEF + 18
) (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire logic [NW-1:0]    num,
	input  wire logic [DEN_W-1:0] den,
	output      logic [NW-1:0]    q
);
	logic [NW-1:0]    nq_s  [1:NW];
	logic [DEN_W-1:0] rem_s [1:NW];
	logic [DEN_W-1:0] den_s [1:NW];

	for (genvar j = 1; j <= NW; j++) begin : g_stage
		logic [NW-1:0]    pnq;
		logic [DEN_W-1:0] prem;
		logic [DEN_W-1:0] pden;
		logic [DEN_W:0]   sh;
		logic [DEN_W:0]   diff;
		logic             ge;

		if (j == 1) begin : g_first
			assign pnq  = num;
			assign prem = '0;
			assign pden = den;
		end else begin : g_next
			assign pnq  = nq_s[j-1];
			assign prem = rem_s[j-1];
			assign pden = den_s[j-1];
		end

		// The dividend shifts out at the top while quotient bits enter below.
		assign sh   = {prem, pnq[NW-1]};
		assign ge   = sh >= {1'b0, pden};
		assign diff = sh - {1'b0, pden};

		always_ff @(posedge clk) begin
			if (en) begin
				nq_s[j]  <= {pnq[NW-2:0], ge};
				rem_s[j] <= ge ? diff[DEN_W-1:0] : sh[DEN_W-1:0];
				den_s[j] <= pden;
			end
		end
	end

	assign q = nq_s[NW];
endmodule
`default_nettype wire

FILE: hdl/quadratic_root_solver_core.sv
// Quadratic root solver: one coefficient request per cycle unless the output stalls.
// The pipeline consists of the square root, which resolves one root bit per stage
// over FRACTION_BITS+17 stages, and the two dividers, which resolve one quotient bit
// per stage over FRACTION_BITS+18 stages, plus five stages for the products, the
// discriminant, the signed operands and the final sign and saturation. When the
// result is not taken the whole pipeline holds, so a stalled output loses nothing.
`timescale 1ns / 1ps
`default_nettype none
module quadratic_root_solver_core import qrs_pkg::*; #(
	parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
	input wire logic  clk,
	input wire logic  arst_n,
	qrs_coef_if.sink  coef,
	qrs_root_if.source root
);
	localparam int N   = DISC_W / 2 + FRACTION_BITS;
	localparam int NW  = FRACTION_BITS + 18;
	localparam int NBW = FRACTION_BITS + 17;
	localparam int EW  = (NW + 1 > ROOT_W + 1) ? NW + 1 : ROOT_W + 1;
	localparam logic [EW-1:0] LIM_POS = {{(EW-ROOT_W+1){1'b0}}, {(ROOT_W-1){1'b1}}};
	localparam logic [EW-1:0] LIM_NEG = {{(EW-ROOT_W){1'b0}}, 1'b1, {(ROOT_W-1){1'b0}}};

	logic en;
	logic v_s5;

	assign en         = !v_s5 || root.ready;
	assign coef.ready = en;

	// Stage 1: capture.
	logic                     v_s1;
	logic signed [COEF_W-1:0] a_s1, b_s1, c_s1;
	// Stage 2: products.
	logic                     v_s2;
	logic signed [COEF_W-1:0] a_s2, b_s2;
	logic signed [2*COEF_W-1:0] bb_s2, ac_s2;
	// Stage 3: discriminant and operands.
	logic                     v_s3;
	logic signed [DISC_W-1:0] delta_s3;
	root_case_t               kind_s3;
	logic signed [NBW-1:0]    nb_s3;
	logic signed [DEN_W-1:0]  den_s3;

	logic signed [DISC_W-1:0] delta_c;
	root_case_t               kind_c;

	assign delta_c = DISC_W'(bb_s2) - (DISC_W'(ac_s2) <<< 2);

	always_comb begin
		if (a_s2 == '0)
			kind_c = CASE_LINEAR;
		else if (delta_c[DISC_W-1])
			kind_c = CASE_NONE;
		else if (delta_c == '0)
			kind_c = CASE_DOUBLE;
		else
			kind_c = CASE_TWO;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1     <= coef.coef_a;
			b_s1     <= coef.coef_b;
			c_s1     <= coef.coef_c;
			a_s2     <= a_s1;
			b_s2     <= b_s1;
			bb_s2    <= b_s1 * b_s1;
			ac_s2    <= a_s1 * c_s1;
			delta_s3 <= delta_c;
			kind_s3  <= kind_c;
			nb_s3    <= -(NBW'(b_s2) <<< FRACTION_BITS);
			den_s3   <= DEN_W'(a_s2) <<< 1;
		end
	end

	// Square root over the nonnegative discriminant.
	logic [DISC_W-1:0] rad;
	logic [N-1:0]      sq;

	assign rad = delta_s3[DISC_W-1] ? '0 : delta_s3;

	qrs_sqrt #(.FRACTION_BITS(FRACTION_BITS)) u_sqrt (
		.clk (clk),
		.en  (en),
		.d   (rad),
		.s   (sq)
	);

	logic                     va_s   [1:N];
	logic signed [DISC_W-1:0] dla_s  [1:N];
	root_case_t               kda_s  [1:N];
	logic signed [NBW-1:0]    nba_s  [1:N];
	logic signed [DEN_W-1:0]  dna_s  [1:N];

	always_ff @(posedge clk) begin
		if (en) begin
			dla_s[1] <= delta_s3;
			kda_s[1] <= kind_s3;
			nba_s[1] <= nb_s3;
			dna_s[1] <= den_s3;
			for (int k = 2; k <= N; k++) begin
				dla_s[k] <= dla_s[k-1];
				kda_s[k] <= kda_s[k-1];
				nba_s[k] <= nba_s[k-1];
				dna_s[k] <= dna_s[k-1];
			end
		end
	end

	// Stage 4: signed numerators split into magnitude and quotient sign.
	logic signed [NW:0]       nump_c, numm_c, nbx_c, sx_c;
	logic [NW:0]              absp_c, absm_c;
	logic                     v_s4;
	logic [NW-1:0]            unp_s4, unm_s4;
	logic [DEN_W-1:0]         ud_s4;
	logic                     negp_s4, negm_s4;
	logic signed [DISC_W-1:0] delta_s4;
	root_case_t               kind_s4;

	assign nbx_c  = (NW+1)'(nba_s[N]);
	assign sx_c   = signed'({{(NW+1-N){1'b0}}, sq});
	assign nump_c = nbx_c + sx_c;
	assign numm_c = nbx_c - sx_c;
	assign absp_c = nump_c[NW] ? -nump_c : nump_c;
	assign absm_c = numm_c[NW] ? -numm_c : numm_c;

	always_ff @(posedge clk) begin
		if (en) begin
			unp_s4   <= absp_c[NW-1:0];
			unm_s4   <= absm_c[NW-1:0];
			ud_s4    <= dna_s[N][DEN_W-1] ? -dna_s[N] : dna_s[N];
			negp_s4  <= nump_c[NW] != dna_s[N][DEN_W-1];
			negm_s4  <= numm_c[NW] != dna_s[N][DEN_W-1];
			delta_s4 <= dla_s[N];
			kind_s4  <= kda_s[N];
		end
	end

	logic [NW-1:0] qp, qm;

	qrs_div #(.NW(NW)) u_div_plus (
		.clk (clk),
		.en  (en),
		.num (unp_s4),
		.den (ud_s4),
		.q   (qp)
	);

	qrs_div #(.NW(NW)) u_div_minus (
		.clk (clk),
		.en  (en),
		.num (unm_s4),
		.den (ud_s4),
		.q   (qm)
	);

	logic                     vb_s   [1:NW];
	logic signed [DISC_W-1:0] dlb_s  [1:NW];
	root_case_t               kdb_s  [1:NW];
	logic                     npb_s  [1:NW];
	logic                     nmb_s  [1:NW];

	always_ff @(posedge clk) begin
		if (en) begin
			dlb_s[1] <= delta_s4;
			kdb_s[1] <= kind_s4;
			npb_s[1] <= negp_s4;
			nmb_s[1] <= negm_s4;
			for (int k = 2; k <= NW; k++) begin
				dlb_s[k] <= dlb_s[k-1];
				kdb_s[k] <= kdb_s[k-1];
				npb_s[k] <= npb_s[k-1];
				nmb_s[k] <= nmb_s[k-1];
			end
		end
	end

	// Stage 5: sign, saturation and the cases without real roots.
	function automatic logic [ROOT_W-1:0] apply_sign(input logic [NW-1:0] q,
		input logic neg);
		logic [EW-1:0] qe;
		logic [EW-1:0] qn;
		qe = EW'(q);
		qn = -qe;
		if (neg)
			apply_sign = (qe > LIM_NEG) ? ROOT_MIN : qn[ROOT_W-1:0];
		else
			apply_sign = (qe > LIM_POS) ? ROOT_MAX : qe[ROOT_W-1:0];
	endfunction

	logic signed [DISC_W-1:0] delta_s5;
	root_case_t               kind_s5;
	logic [ROOT_W-1:0]        rp_s5, rm_s5;
	logic                     real_c;

	assign real_c = kdb_s[NW] == CASE_TWO || kdb_s[NW] == CASE_DOUBLE;

	always_ff @(posedge clk) begin
		if (en) begin
			delta_s5 <= dlb_s[NW];
			kind_s5  <= kdb_s[NW];
			rp_s5    <= real_c ? apply_sign(qp, npb_s[NW]) : '0;
			rm_s5    <= real_c ? apply_sign(qm, nmb_s[NW]) : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			for (int k = 1; k <= N; k++)
				va_s[k] <= 1'b0;
			for (int k = 1; k <= NW; k++)
				vb_s[k] <= 1'b0;
		end else if (en) begin
			v_s1    <= coef.valid;
			v_s2    <= v_s1;
			v_s3    <= v_s2;
			va_s[1] <= v_s3;
			for (int k = 2; k <= N; k++)
				va_s[k] <= va_s[k-1];
			v_s4    <= va_s[N];
			vb_s[1] <= v_s4;
			for (int k = 2; k <= NW; k++)
				vb_s[k] <= vb_s[k-1];
			v_s5    <= vb_s[NW];
		end
	end

	assign root.valid        = v_s5;
	assign root.discriminant = delta_s5;
	assign root.root_case    = kind_s5;
	assign root.root_plus    = rp_s5;
	assign root.root_minus   = rm_s5;
endmodule
`default_nettype wire

FILE: hdl/qrs_checker.sv
// Port-level checks of the root solver and their binding to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "quadratic_root_solver_core_defines.svh"
module qrs_checker import qrs_pkg::*; (
	input wire logic                     clk,
	input wire logic                     arst_n,
	input wire logic                     in_ready,
	input wire logic                     out_valid,
	input wire logic                     out_ready,
	input wire logic signed [DISC_W-1:0] disc,
	input wire logic [1:0]               rcase,
	input wire logic signed [ROOT_W-1:0] rp,
	input wire logic signed [ROOT_W-1:0] rm
);
	`QRS_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid, "result dropped while stalled")
	`QRS_ASSERT_IMPLY(a_ready, clk, arst_n, 1'b1, in_ready == (!out_valid || out_ready), "input ready does not follow the output side")
	`QRS_ASSERT_IMPLY(a_real, clk, arst_n, out_valid && (rcase == CASE_TWO || rcase == CASE_DOUBLE), !disc[DISC_W-1], "real roots reported for a negative discriminant")
	`QRS_ASSERT_IMPLY(a_zero, clk, arst_n, out_valid && (rcase == CASE_NONE || rcase == CASE_LINEAR), rp == '0 && rm == '0, "roots not cleared without real roots")
	`QRS_ASSERT_IMPLY(a_double, clk, arst_n, out_valid && rcase == CASE_DOUBLE, disc == '0 && rp == rm, "double root not consistent")
endmodule

bind quadratic_root_solver_core qrs_checker u_qrs_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (coef.ready),
	.out_valid (root.valid),
	.out_ready (root.ready),
	.disc      (root.discriminant),
	.rcase     (root.root_case),
	.rp        (root.root_plus),
	.rm        (root.root_minus)
);
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the quadratic root solver core.
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import qrs_pkg::*;

	localparam int FB = FRACTION_BITS_DEF;
	localparam int LATENCY = 2 * FB + 40;
	localparam int RANDOM_REQUESTS = 1184;
	localparam longint CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic signed [DISC_W-1:0] discriminant;
		root_case_t               root_case;
		logic signed [ROOT_W-1:0] root_plus;
		logic signed [ROOT_W-1:0] root_minus;
	} roots_t;

	// Keeps the expected roots of every accepted request in order of arrival.
	class root_scoreboard;
		roots_t pending[$];
		int     errors;

		// Integer square root of d * 2^(2*FB), two bits per step.
		function automatic longint unsigned scaled_sqrt(longint unsigned d);
			longint unsigned r, rem, pair, trial;
			r = 0;
			rem = 0;
			for (int i = 16 + FB; i >= 0; i--) begin
				pair = (i >= FB) ? ((d >> (2 * (i - FB))) & 3) : 0;
				rem = (rem << 2) | pair;
				trial = (r << 2) | 1;
				if (rem >= trial) begin
					rem -= trial;
					r = (r << 1) | 1;
				end else begin
					r = r << 1;
				end
			end
			return r;
		endfunction

		function automatic longint trunc_div(longint num, longint den);
			longint q;
			q = num / den;
			if (q > 64'sd8589934591)
				q = 64'sd8589934591;
			if (q < -64'sd8589934592)
				q = -64'sd8589934592;
			return q;
		endfunction

		function void note_coefficients(logic signed [COEF_W-1:0] a,
				logic signed [COEF_W-1:0] b, logic signed [COEF_W-1:0] c);
			roots_t exp_roots;
			longint delta, s, nb;
			delta = longint'(b) * longint'(b) - 4 * longint'(a) * longint'(c);
			exp_roots.discriminant = delta[DISC_W-1:0];
			exp_roots.root_plus = '0;
			exp_roots.root_minus = '0;
			if (a == 0) begin
				exp_roots.root_case = CASE_LINEAR;
			end else if (delta < 0) begin
				exp_roots.root_case = CASE_NONE;
			end else begin
				s = longint'(scaled_sqrt(longint'(delta)));
				nb = -longint'(b) * (64'sd1 <<< FB);
				exp_roots.root_case = (delta == 0) ? CASE_DOUBLE : CASE_TWO;
				exp_roots.root_plus = ROOT_W'(trunc_div(nb + s, 2 * longint'(a)));
				exp_roots.root_minus = ROOT_W'(trunc_div(nb - s, 2 * longint'(a)));
			end
			pending.push_back(exp_roots);
		endfunction

		function void check_roots(roots_t got);
			roots_t exp_roots;
			if (pending.size() == 0) begin
				$error("unexpected result discriminant=%0d", got.discriminant);
				errors++;
				return;
			end
			exp_roots = pending.pop_front();
			if (got.discriminant !== exp_roots.discriminant) begin
				$error("discriminant: expected %0d, got %0d",
					exp_roots.discriminant, got.discriminant);
				errors++;
			end
			if (got.root_case !== exp_roots.root_case) begin
				$error("root_case: expected %0d, got %0d",
					exp_roots.root_case, got.root_case);
				errors++;
			end
			if (got.root_plus !== exp_roots.root_plus) begin
				$error("root_plus: expected %0d, got %0d",
					exp_roots.root_plus, got.root_plus);
				errors++;
			end
			if (got.root_minus !== exp_roots.root_minus) begin
				$error("root_minus: expected %0d, got %0d",
					exp_roots.root_minus, got.root_minus);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	longint cycles = 0;
	logic long_hold = 1'b0;
	root_scoreboard sb = new();

	qrs_coef_if coef();
	qrs_root_if root();

	quadratic_root_solver_core u_top (
		.clk(clk),
		.arst_n(arst_n),
		.coef(coef.sink),
		.root(root.source)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	always @(posedge clk)
		if (arst_n && root.valid && root.ready)
			sb.check_roots({root.discriminant, root_case_t'(root.root_case),
				root.root_plus, root.root_minus});

	// Receiver stall pattern: periods of steady readiness alternate with random stalls.
	int stall_mode = 0;
	always @(posedge clk) begin
		if (!arst_n) begin
			root.ready <= 1'b0;
		end else if (long_hold) begin
			root.ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0)
				stall_mode = $urandom_range(0, 2);
			case (stall_mode)
				0: root.ready <= 1'b1;
				1: root.ready <= ($urandom_range(0, 3) != 0);
				default: root.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Offers one request and holds it until the block takes it.
	task automatic send_coefficients(logic signed [COEF_W-1:0] a,
			logic signed [COEF_W-1:0] b, logic signed [COEF_W-1:0] c);
		coef.valid <= 1'b1;
		coef.coef_a <= a;
		coef.coef_b <= b;
		coef.coef_c <= c;
		@(posedge clk);
		while (!coef.ready)
			@(posedge clk);
		sb.note_coefficients(a, b, c);
	endtask

	task automatic idle_gap(int n);
		coef.valid <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	function automatic logic signed [COEF_W-1:0] pick_coef();
		case ($urandom_range(0, 5))
			0: return 16'sh7FFF;
			1: return 16'sh8000;
			2: return 16'(int'($urandom_range(0, 16)) - 8);
			3: return 16'(int'($urandom_range(0, 512)) - 256);
			default: return 16'($urandom);
		endcase
	endfunction

	// One in four draws builds a, b, c from set roots; double and real roots come often.
	task automatic send_random;
		logic signed [COEF_W-1:0] a, b, c;
		int r1, r2, k;
		case ($urandom_range(0, 3))
			0: begin
				k = $urandom_range(1, 8) * ($urandom_range(0, 1) ? 1 : -1);
				r1 = int'($urandom_range(0, 40)) - 20;
				r2 = ($urandom_range(0, 2) == 0) ? r1 : int'($urandom_range(0, 40)) - 20;
				a = 16'(k);
				b = 16'(-k * (r1 + r2));
				c = 16'(k * r1 * r2);
			end
			default: begin
				a = pick_coef();
				b = pick_coef();
				c = pick_coef();
			end
		endcase
		send_coefficients(a, b, c);
	endtask

	task automatic wait_drained;
		while (sb.pending.size() != 0)
			@(posedge clk);
	endtask

	initial begin
		logic signed [COEF_W-1:0] corner[5];
		int burst;
		coef.valid = 1'b0;
		coef.coef_a = '0;
		coef.coef_b = '0;
		coef.coef_c = '0;
		corner = '{16'sh7FFF, 16'sh8000, 16'sh0000, 16'sh0001, 16'shFFFF};
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes of every coefficient, linear, double and complex cases.
		send_coefficients(16'sh8000, 16'sh8000, 16'sh7FFF);
		send_coefficients(16'sh8000, 16'sh7FFF, 16'sh8000);
		send_coefficients(16'sh7FFF, 16'sh8000, 16'sh8000);
		send_coefficients(16'sh0000, 16'sh1234, 16'sh0055);
		send_coefficients(16'sh0000, 16'sh0000, 16'sh0000);
		send_coefficients(16'sh0001, 16'sh0002, 16'sh0001);
		send_coefficients(16'shFFFF, 16'sh0004, 16'shFFFC);
		send_coefficients(16'sh0001, 16'sh0000, 16'sh0001);
		send_coefficients(16'sh0001, 16'sh0000, 16'shFFFF);
		send_coefficients(16'sh0001, 16'sh7FFF, 16'sh0000);
		send_coefficients(16'shFFFF, 16'sh8000, 16'sh7FFF);
		for (int i = 0; i < 5; i++)
			send_coefficients(corner[i], corner[(i + 2) % 5], corner[(i + 4) % 5]);
		idle_gap(1);
		wait_drained();

		// Long receiver hold while requests keep coming, so the pipeline backs up.
		fork
			begin
				long_hold <= 1'b1;
				repeat (LATENCY * 3) @(posedge clk);
				long_hold <= 1'b0;
			end
			for (int i = 0; i < 150; i++)
				send_random();
		join

		for (int sent = 0; sent < RANDOM_REQUESTS; ) begin
			burst = $urandom_range(1, 40);
			for (int j = 0; j < burst && sent < RANDOM_REQUESTS; j++) begin
				send_random();
				sent++;
			end
			if ($urandom_range(0, 2) == 0)
				idle_gap($urandom_range(1, 12));
		end
		idle_gap(1);

		wait_drained();
		repeat (LATENCY + 10) @(posedge clk);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
`default_nettype wire

FILE: sim.f
+incdir+hdl
hdl/qrs_pkg.sv
hdl/qrs_coef_if.sv
hdl/qrs_root_if.sv
hdl/qrs_sqrt.sv
hdl/qrs_div.sv
hdl/quadratic_root_solver_core.sv
hdl/qrs_checker.sv
test/tb.sv
